/* hdl/stbs_pkg.sv */
// ----------------------------------------------------------------------------
// stbs_pkg
// Shared constants, request codes and types of the sorted-table search unit.
// ----------------------------------------------------------------------------
package stbs_pkg;

    localparam int TABLE_DEPTH_DEF = 1024;
    localparam int KEY_WIDTH_DEF   = 32;

    // Field widths of the stream beats
    localparam int IDX_W     = 10;
    localparam int VAL_W     = 32;
    localparam int CNT_W     = 4;
    localparam int POS_W     = 10;
    localparam int CFG_W     = 10;
    localparam int ADDR_EXT_W = 17;

    // Input tdata layout, lowest bit up: entry_index, entry_value, search_key
    localparam int IDX_LSB    = 0;
    localparam int VALUE_LSB  = IDX_LSB + IDX_W;
    localparam int KEY_LSB    = VALUE_LSB + VAL_W;
    localparam int S_USED_W   = KEY_LSB + VAL_W;
    localparam int S_TDATA_W  = ((S_USED_W + 7) / 8) * 8;

    // Output tdata layout, lowest bit up: probe_count, found, position
    localparam int M_USED_W   = CNT_W + 1 + POS_W;
    localparam int M_TDATA_W  = ((M_USED_W + 7) / 8) * 8;
    localparam int M_PAD_W    = M_TDATA_W - M_USED_W;

    localparam logic [CFG_W-1:0] HIGHEST_INDEX_RST = 10'd1023;

    // Request kinds carried in s_tuser
    localparam logic REQ_WRITE  = 1'b0;
    localparam logic REQ_SEARCH = 1'b1;

    typedef struct packed {
        logic hit;
        logic exhausted;
    } stbs_probe_status_t;

endpackage

/* hdl/stbs_table_ram.sv */
// ----------------------------------------------------------------------------
// stbs_table_ram
// Key table: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module stbs_table_ram #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10,
    parameter int DW    = 32
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic [AW-1:0] raddr,
    output logic [DW-1:0] rdata
);

    logic [DW-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

/* hdl/stbs_probe_unit.sv */
// ----------------------------------------------------------------------------
// stbs_probe_unit
// Shared compare unit: checks one probed entry against the key and narrows
// the search window, producing the next midpoint.
// ----------------------------------------------------------------------------
module stbs_probe_unit #(
    parameter int KEY_WIDTH = 32,
    parameter int BW        = 12
) (
    input  logic signed [KEY_WIDTH-1:0] key,
    input  logic signed [KEY_WIDTH-1:0] entry,
    input  logic signed [BW-1:0]        low,
    input  logic signed [BW-1:0]        high,
    input  logic signed [BW-1:0]        mid,
    output logic signed [BW-1:0]        low_next,
    output logic signed [BW-1:0]        high_next,
    output logic signed [BW-1:0]        mid_next,
    output stbs_pkg::stbs_probe_status_t status
);
    import stbs_pkg::*;

    localparam logic signed [BW-1:0] ONE = BW'(1);

    logic                 hit;
    logic                 less;
    logic signed [BW-1:0] sum;

    always_comb
    begin
        hit  = (entry == key);
        less = (entry < key);
        // entry below key: search upper half, else lower half
        low_next  = less ? (mid + ONE) : low;
        high_next = less ? high : (mid - ONE);
        sum       = low_next + high_next;
        mid_next  = sum >>> 1;
        status.hit       = hit;
        status.exhausted = !hit && (low_next > high_next);
    end

endmodule

/* hdl/sorted_table_binary_search_unit.sv */
// ----------------------------------------------------------------------------
// sorted_table_binary_search_unit
// Binary search over a loaded table of signed keys, one probe per cycle.
// ----------------------------------------------------------------------------
// Write beat: no result beat; writes can follow back to back.
// Search beat: p probes (1 to log2(TABLE_DEPTH)+1, 11 at depth 1024), one per
// cycle; no new beat is taken until the search ends and its result beat is
// registered.
// A result still held at the output stalls the final probe until it leaves.
// Reset (rst_n low, asynchronous) sets highest_index to 1023, idles the sequencer.
module sorted_table_binary_search_unit #(
    parameter int TABLE_DEPTH = stbs_pkg::TABLE_DEPTH_DEF,
    parameter int KEY_WIDTH   = stbs_pkg::KEY_WIDTH_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // entry_index[9:0], entry_value[41:10], search_key[73:42], zero pad
    input  logic [stbs_pkg::S_TDATA_W-1:0] s_tdata,
    // req_type
    input  logic                           s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // probe_count[3:0], found[4], position[14:5], zero pad
    output logic [stbs_pkg::M_TDATA_W-1:0] m_tdata,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [stbs_pkg::CFG_W-1:0]     cfg_data
);
    import stbs_pkg::*;

    localparam int AW = (TABLE_DEPTH > 2) ? $clog2(TABLE_DEPTH) : 1;
    localparam int BW = AW + 2;
    localparam logic [ADDR_EXT_W-1:0] DEPTH_EXT    = ADDR_EXT_W'(TABLE_DEPTH);
    localparam logic [ADDR_EXT_W-1:0] DEPTH_M1_EXT = ADDR_EXT_W'(TABLE_DEPTH - 1);

    typedef enum logic {
        ST_IDLE,
        ST_SEARCH
    } state_t;

    state_t                      state_reg, state_next;
    logic        [CFG_W-1:0]     highest_index_reg;
    logic signed [KEY_WIDTH-1:0] key_reg, key_next;
    logic signed [BW-1:0]        low_reg, low_next;
    logic signed [BW-1:0]        high_reg, high_next;
    logic signed [BW-1:0]        mid_reg, mid_next;
    logic        [CNT_W-1:0]     cnt_reg, cnt_next;
    logic                        m_valid_reg, m_valid_next;
    logic        [CNT_W-1:0]     out_cnt_reg, out_cnt_next;
    logic                        out_found_reg, out_found_next;
    logic        [POS_W-1:0]     out_pos_reg, out_pos_next;

    logic        [IDX_W-1:0]      in_index;
    logic        [VAL_W-1:0]      in_value;
    logic        [VAL_W-1:0]      in_key;
    logic        [63:0]           value_wide;
    logic        [63:0]           key_wide;
    logic signed [KEY_WIDTH-1:0]  in_key_k;
    logic        [ADDR_EXT_W-1:0] index_ext;
    logic        [ADDR_EXT_W-1:0] hi_ext;
    logic        [ADDR_EXT_W-1:0] bound_ext;
    logic signed [BW-1:0]         bound;
    logic signed [BW-1:0]         first_mid;
    logic signed [BW-1:0]         raddr_full;
    logic        [31:0]           pos_wide;

    logic                         s_take;
    logic                         ram_we;
    logic signed [KEY_WIDTH-1:0]  ram_rdata;
    logic signed [BW-1:0]         pu_low, pu_high, pu_mid;
    stbs_probe_status_t           pu_status;
    logic                         done;
    logic                         stall;

    assign in_index  = s_tdata[VALUE_LSB-1:IDX_LSB];
    assign in_value  = s_tdata[KEY_LSB-1:VALUE_LSB];
    assign in_key    = s_tdata[S_USED_W-1:KEY_LSB];
    assign value_wide = {{(64 - VAL_W){in_value[VAL_W-1]}}, in_value};
    assign key_wide   = {{(64 - VAL_W){in_key[VAL_W-1]}}, in_key};
    assign in_key_k   = key_wide[KEY_WIDTH-1:0];

    assign index_ext = ADDR_EXT_W'(in_index);
    assign hi_ext    = ADDR_EXT_W'(highest_index_reg);
    // saturate the upper bound to the last table entry
    assign bound_ext = (hi_ext > DEPTH_M1_EXT) ? DEPTH_M1_EXT : hi_ext;
    assign bound     = BW'(bound_ext);
    assign first_mid = bound >>> 1;

    assign s_tready  = (state_reg == ST_IDLE);
    assign s_take    = s_tvalid && s_tready;
    assign ram_we    = s_take && (s_tuser == REQ_WRITE) && (index_ext < DEPTH_EXT);
    assign cfg_ready = 1'b1;

    assign done  = pu_status.hit || pu_status.exhausted;
    assign stall = m_valid_reg && !m_tready;

    // hold the read address on a stalled final probe so the entry stays put
    always_comb
    begin
        case (state_reg)
            ST_IDLE:   raddr_full = first_mid;
            ST_SEARCH: raddr_full = done ? mid_reg : pu_mid;
            default:   raddr_full = first_mid;
        endcase
    end

    stbs_table_ram #(
        .DEPTH (TABLE_DEPTH),
        .AW    (AW),
        .DW    (KEY_WIDTH)
    ) u_table_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (index_ext[AW-1:0]),
        .wdata (value_wide[KEY_WIDTH-1:0]),
        .raddr (raddr_full[AW-1:0]),
        .rdata (ram_rdata)
    );

    stbs_probe_unit #(
        .KEY_WIDTH (KEY_WIDTH),
        .BW        (BW)
    ) u_probe_unit (
        .key       (key_reg),
        .entry     (ram_rdata),
        .low       (low_reg),
        .high      (high_reg),
        .mid       (mid_reg),
        .low_next  (pu_low),
        .high_next (pu_high),
        .mid_next  (pu_mid),
        .status    (pu_status)
    );

    assign pos_wide = 32'(mid_reg);

    always_comb
    begin
        state_next     = state_reg;
        key_next       = key_reg;
        low_next       = low_reg;
        high_next      = high_reg;
        mid_next       = mid_reg;
        cnt_next       = cnt_reg;
        m_valid_next   = m_valid_reg && !m_tready;
        out_cnt_next   = out_cnt_reg;
        out_found_next = out_found_reg;
        out_pos_next   = out_pos_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_take && (s_tuser == REQ_SEARCH))
                begin
                    key_next   = in_key_k;
                    low_next   = '0;
                    high_next  = bound;
                    mid_next   = first_mid;
                    cnt_next   = '0;
                    state_next = ST_SEARCH;
                end
            end
            ST_SEARCH:
            begin
                if (done)
                begin
                    if (!stall)
                    begin
                        m_valid_next   = 1'b1;
                        out_cnt_next   = cnt_reg + CNT_W'(1);
                        out_found_next = pu_status.hit;
                        out_pos_next   = pu_status.hit ? pos_wide[POS_W-1:0] : '0;
                        state_next     = ST_IDLE;
                    end
                end
                else
                begin
                    low_next  = pu_low;
                    high_next = pu_high;
                    mid_next  = pu_mid;
                    cnt_next  = cnt_reg + CNT_W'(1);
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            highest_index_reg <= HIGHEST_INDEX_RST;
            key_reg           <= '0;
            low_reg           <= '0;
            high_reg          <= '0;
            mid_reg           <= '0;
            cnt_reg           <= '0;
            m_valid_reg       <= 1'b0;
            out_cnt_reg       <= '0;
            out_found_reg     <= 1'b0;
            out_pos_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            key_reg       <= key_next;
            low_reg       <= low_next;
            high_reg      <= high_next;
            mid_reg       <= mid_next;
            cnt_reg       <= cnt_next;
            m_valid_reg   <= m_valid_next;
            out_cnt_reg   <= out_cnt_next;
            out_found_reg <= out_found_next;
            out_pos_reg   <= out_pos_next;
            if (cfg_valid && cfg_ready)
            begin
                highest_index_reg <= cfg_data;
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{M_PAD_W{1'b0}}, out_pos_reg, out_found_reg, out_cnt_reg};

    a_window_open: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SEARCH) |-> (low_reg <= high_reg))
        else $error("search window empty while searching");

    a_mid_inside: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SEARCH) |-> ((mid_reg >= low_reg) && (mid_reg <= high_reg)))
        else $error("probe midpoint outside search window");

    a_busy_after_search: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && (s_tuser == REQ_SEARCH)) |=> !s_tready)
        else $error("input taken during a search");

    a_miss_position: assert property (@(posedge clk) disable iff (!rst_n)
        (m_valid_reg && !out_found_reg) |-> (out_pos_reg == '0))
        else $error("miss result carries a nonzero position");

endmodule
